/* rtl/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, constants and the per-byte run decision of the string scanner.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 8;
    localparam int LIMIT_W  = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam int MAX_LEN  = 256;
    localparam int LEN_CAP  = (MAX_LEN - 1 > 255) ? 255 : MAX_LEN - 1;
    localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);

    localparam logic [LEN_W-1:0]   DEFAULT_MIN   = 8'd5;
    localparam logic [LEN_W-1:0]   SHORTEST_RUN  = 8'd2;
    localparam logic [DATA_W-1:0]  PRINT_LO      = 8'h20;
    localparam logic [DATA_W-1:0]  PRINT_HI      = 8'h7E;
    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_MIN_LENGTH   = 2'd0,
        REG_STRING_LIMIT = 2'd1,
        REG_REGION_START = 2'd2,
        REG_REGION_RVA   = 2'd3
    } pss_reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]   min_length;
        logic [LIMIT_W-1:0] string_limit;
        logic [ADDR_W-1:0]  region_start;
        logic [ADDR_W-1:0]  region_rva;
    } pss_cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] start;
        logic              hit;
        logic [LEN_W-1:0]  hit_len;
    } pss_run_t;

    function automatic pss_run_t pss_decide(
        input pss_run_t          cur,
        input logic [DATA_W-1:0] b,
        input logic [ADDR_W-1:0] pos,
        input logic              en,
        input logic [LEN_W-1:0]  min_eff
    );
        pss_run_t r;
        r         = cur;
        r.hit     = 1'b0;
        r.hit_len = cur.len;
        if (en)
        begin
            if (b >= PRINT_LO && b <= PRINT_HI)
            begin
                if (cur.len == '0)
                begin
                    r.start = pos;
                end
                if (cur.len < LEN_CAP_V)
                begin
                    r.len = cur.len + LEN_W'(1);
                end
            end
            else
            begin
                r.hit = (cur.len >= min_eff) && (cur.len > SHORTEST_RUN);
                r.len = '0;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/pss_byte_if.sv */
// ----------------------------------------------------------------------------
// pss_byte_if
// Byte stream channel: one raw byte of the region per beat.
// ----------------------------------------------------------------------------
interface pss_byte_if;
    import pss_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/pss_string_if.sv */
// ----------------------------------------------------------------------------
// pss_string_if
// Result channel: one reported string per beat.
// ----------------------------------------------------------------------------
interface pss_string_if;
    import pss_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] string_offset;
    logic [ADDR_W-1:0] string_rva;
    logic [LEN_W-1:0]  string_length;
    logic              wide_flag;

    modport source (output valid, output string_offset, output string_rva,
                    output string_length, output wide_flag, input ready);
    modport sink   (input valid, input string_offset, input string_rva,
                    input string_length, input wide_flag, output ready);
endinterface

/* rtl/pss_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pss_cfg_regs
// APB register file holding the scanner configuration.
// ----------------------------------------------------------------------------
module pss_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pss_pkg::APB_AW-1:0] paddr,
    input  logic [pss_pkg::APB_DW-1:0] pwdata,
    output logic [pss_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output pss_pkg::pss_cfg_t          cfg
);
    import pss_pkg::*;

    pss_cfg_t     cfg_reg;
    pss_reg_idx_t idx;
    logic         wr_en;

    assign idx    = pss_reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length   <= DEFAULT_MIN;
            cfg_reg.string_limit <= DEFAULT_LIMIT;
            cfg_reg.region_start <= '0;
            cfg_reg.region_rva   <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIN_LENGTH:   cfg_reg.min_length   <= pwdata[LEN_W-1:0];
                REG_STRING_LIMIT: cfg_reg.string_limit <= pwdata[LIMIT_W-1:0];
                REG_REGION_START: cfg_reg.region_start <= pwdata[ADDR_W-1:0];
                REG_REGION_RVA:   cfg_reg.region_rva   <= pwdata[ADDR_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MIN_LENGTH:   prdata = APB_DW'(cfg_reg.min_length);
            REG_STRING_LIMIT: prdata = APB_DW'(cfg_reg.string_limit);
            REG_REGION_START: prdata = APB_DW'(cfg_reg.region_start);
            REG_REGION_RVA:   prdata = APB_DW'(cfg_reg.region_rva);
        endcase
    end

endmodule

/* rtl/printable_string_scanner_core.sv */
// ----------------------------------------------------------------------------
// printable_string_scanner_core
// Finds runs of printable bytes (0x20 to 0x7E) in a byte stream, one region at
// a time, and reports offset, virtual address, length and a wide flag for each
// run over two bytes that reaches the minimum length, up to the string limit.
// The core takes one byte per clock unless stalled: the run counter and a
// two-byte lookahead queue are updated in a single pass, and a reported string
// appears in the result register on the cycle after the beat that decides it.
// The byte channel keeps accepting while a result is held, if the result
// register is emptied in the same cycle; each byte gives at most one string.
// ----------------------------------------------------------------------------
module printable_string_scanner_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pss_pkg::APB_AW-1:0] paddr,
    input  logic [pss_pkg::APB_DW-1:0] pwdata,
    output logic [pss_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    pss_byte_if.sink                   scan,
    pss_string_if.source               report
);
    import pss_pkg::*;

    pss_cfg_t cfg;

    pss_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic              open_reg;
    logic [1:0]        fill_reg;
    logic [DATA_W-1:0] q0_reg, q1_reg;
    logic [LEN_W-1:0]  run_len_reg;
    logic [ADDR_W-1:0] run_start_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [LIMIT_W-1:0] count_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_offset_reg;
    logic [ADDR_W-1:0] out_rva_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_wide_reg;

    logic              accept;
    logic              last;
    logic [DATA_W-1:0] b, s0, s1, s2;
    logic [1:0]        fill, n;
    logic [ADDR_W-1:0] base_pos;
    logic [LEN_W-1:0]  min_eff;
    logic              dec0, dec1, dec2;
    logic              full;
    pss_run_t          run_in, run0, run1, run2;
    logic              emit;
    logic [LEN_W-1:0]  emit_len;
    logic              emit_wide;

    assign scan.ready = !out_valid_reg || report.ready;
    assign accept     = scan.valid && scan.ready;
    assign b          = scan.data_byte;
    assign last       = scan.last_byte;

    // a closed region restarts with an empty queue and no run
    assign fill     = open_reg ? fill_reg : 2'd0;
    assign base_pos = open_reg ? pos_reg : cfg.region_start;
    assign n        = fill + 2'd1;
    assign full     = (n == 2'd3);

    assign s0 = (fill == 2'd0) ? b : q0_reg;
    assign s1 = (fill == 2'd1) ? b : q1_reg;
    assign s2 = b;

    assign dec0 = full || last;
    assign dec1 = last && (n >= 2'd2);
    assign dec2 = last && full;

    assign min_eff = (cfg.min_length == '0) ? DEFAULT_MIN : cfg.min_length;

    always_comb
    begin
        run_in.len     = open_reg ? run_len_reg : '0;
        run_in.start   = run_start_reg;
        run_in.hit     = 1'b0;
        run_in.hit_len = '0;
        run0 = pss_decide(run_in, s0, base_pos, dec0, min_eff);
        run1 = pss_decide(run0, s1, base_pos + ADDR_W'(1), dec1, min_eff);
        run2 = pss_decide(run1, s2, base_pos + ADDR_W'(2), dec2, min_eff);
    end

    // at most one run can end within the bytes decided on one beat
    assign emit = (run0.hit || run1.hit || run2.hit) && (count_reg < cfg.string_limit);

    always_comb
    begin
        priority if (run0.hit)
        begin
            emit_len = run0.hit_len;
        end
        else if (run1.hit)
        begin
            emit_len = run1.hit_len;
        end
        else
        begin
            emit_len = run2.hit_len;
        end
    end

    // lookahead only exists for the head byte of a full queue
    assign emit_wide = run0.hit && full && (s0 == '0) && (s1 != '0) && (s2 == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            fill_reg    <= 2'd0;
            run_len_reg <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                open_reg    <= 1'b0;
                fill_reg    <= 2'd0;
                run_len_reg <= '0;
            end
            else
            begin
                open_reg    <= 1'b1;
                fill_reg    <= full ? 2'd2 : n;
                run_len_reg <= run0.len;
            end
            if (emit)
            begin
                count_reg <= count_reg + LIMIT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q0_reg        <= full ? s1 : s0;
            q1_reg        <= full ? s2 : s1;
            run_start_reg <= run2.start;
            pos_reg       <= full ? base_pos + ADDR_W'(1) : base_pos;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_offset_reg <= run_start_reg;
            out_rva_reg    <= cfg.region_rva + (run_start_reg - cfg.region_start);
            out_len_reg    <= emit_len;
            out_wide_reg   <= emit_wide;
        end
    end

    assign report.valid         = out_valid_reg;
    assign report.string_offset = out_offset_reg;
    assign report.string_rva    = out_rva_reg;
    assign report.string_length = out_len_reg;
    assign report.wide_flag     = out_wide_reg;

endmodule
